### design/amdfs_pkg.sv
// Shared types and constants for the adjacency-matrix depth-first order unit.
package amdfs_pkg;

  localparam int VERTS   = 16;
  localparam int VIDX_W  = $clog2(VERTS);
  localparam int DEPTH_W = $clog2(VERTS) + 1;
  localparam int ROW_W   = 16;
  localparam int CNT_W   = 5;

  localparam logic OP_ROW_WRITE = 1'b0;
  localparam logic OP_START     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_POP
  } state_t;

  typedef struct packed {
    logic              operation;
    logic [VIDX_W-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
    logic [VIDX_W-1:0] start_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0] visited_vertex;
    logic              last_visit;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [VIDX_W-1:0] waddr;
    logic [ROW_W-1:0]  wdata;
    logic              re;
    logic [VIDX_W-1:0] raddr;
  } row_port_t;

  typedef struct packed {
    logic              we;
    logic [VIDX_W-1:0] waddr;
    logic [VIDX_W-1:0] wdata;
    logic              re;
    logic [VIDX_W-1:0] raddr;
  } stack_port_t;

endpackage

### design/amdfs_ram.sv
// Generic simple dual-port RAM with a registered read port.
module amdfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/amdfs_ctrl.sv
// Traversal sequencer: visited mask, stack pointer, pending vertex and result register.
module amdfs_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  amdfs_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output amdfs_pkg::out_item_t         out_data,
  input  logic [amdfs_pkg::CNT_W-1:0]  vertex_count,
  output amdfs_pkg::row_port_t         row_port,
  input  logic [amdfs_pkg::ROW_W-1:0]  row_rdata,
  output amdfs_pkg::stack_port_t       stack_port,
  input  logic [amdfs_pkg::VIDX_W-1:0] stack_rdata
);

  amdfs_pkg::state_t state, state_next;

  logic [amdfs_pkg::VERTS-1:0]   visited;
  logic [amdfs_pkg::DEPTH_W-1:0] depth;
  logic [amdfs_pkg::VIDX_W-1:0]  top;
  logic [amdfs_pkg::VIDX_W-1:0]  pending;

  logic [amdfs_pkg::VERTS-1:0]   lim_mask;
  logic [amdfs_pkg::VERTS-1:0]   cand;
  logic [amdfs_pkg::VIDX_W-1:0]  nxt;
  logic                          found;
  logic                          slot_free;
  logic                          accept;
  logic                          start_ok;
  logic                          push;
  logic                          pop;
  logic                          finish;
  logic                          at_bottom;

  always_comb begin
    for (int i = 0; i < amdfs_pkg::VERTS; i++) begin
      lim_mask[i] = ({1'b0, vertex_count} > (amdfs_pkg::CNT_W + 1)'(i));
    end
  end

  assign cand = row_rdata[amdfs_pkg::VERTS-1:0] & ~visited & lim_mask;

  always_comb begin
    nxt = '0;
    for (int i = amdfs_pkg::VERTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        nxt = amdfs_pkg::VIDX_W'(i);
      end
    end
  end

  assign found     = (|cand) && (depth != amdfs_pkg::DEPTH_W'(amdfs_pkg::VERTS));
  assign slot_free = !out_valid || out_ready;
  assign at_bottom = (depth == amdfs_pkg::DEPTH_W'(1));
  assign accept    = in_valid && (state == amdfs_pkg::ST_IDLE);
  assign start_ok  = accept && (in_data.operation == amdfs_pkg::OP_START);
  assign push      = (state == amdfs_pkg::ST_SCAN) && found && slot_free;
  assign finish    = (state == amdfs_pkg::ST_SCAN) && !found && at_bottom && slot_free;
  assign pop       = (state == amdfs_pkg::ST_SCAN) && !found && !at_bottom;

  always_comb begin
    state_next = state;
    unique case (state)
      amdfs_pkg::ST_IDLE: begin
        if (start_ok) state_next = amdfs_pkg::ST_READ;
      end
      amdfs_pkg::ST_READ: begin
        state_next = amdfs_pkg::ST_SCAN;
      end
      amdfs_pkg::ST_SCAN: begin
        if (push) state_next = amdfs_pkg::ST_READ;
        else if (pop) state_next = amdfs_pkg::ST_POP;
        else if (finish) state_next = amdfs_pkg::ST_IDLE;
      end
      amdfs_pkg::ST_POP: begin
        state_next = amdfs_pkg::ST_SCAN;
      end
      default: state_next = amdfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == amdfs_pkg::ST_IDLE);

    row_port.we    = accept && (in_data.operation == amdfs_pkg::OP_ROW_WRITE);
    row_port.waddr = in_data.row_index;
    row_port.wdata = in_data.row_bits;
    row_port.re    = (state == amdfs_pkg::ST_READ) || (state == amdfs_pkg::ST_POP);
    row_port.raddr = (state == amdfs_pkg::ST_POP) ? stack_rdata : top;

    stack_port.we    = start_ok || push;
    stack_port.waddr = start_ok ? '0 : depth[amdfs_pkg::VIDX_W-1:0];
    stack_port.wdata = start_ok ? in_data.start_vertex : nxt;
    stack_port.re    = pop;
    stack_port.raddr = 
      amdfs_pkg::VIDX_W'(depth - amdfs_pkg::DEPTH_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= amdfs_pkg::ST_IDLE;
      visited   <= '0;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start_ok) begin
        visited <= amdfs_pkg::VERTS'(1) << in_data.start_vertex;
        depth   <= amdfs_pkg::DEPTH_W'(1);
      end else if (push) begin
        visited <= visited | (amdfs_pkg::VERTS'(1) << nxt);
        depth   <= depth + amdfs_pkg::DEPTH_W'(1);
      end else if (pop || finish) begin
        depth   <= depth - amdfs_pkg::DEPTH_W'(1);
      end
      if (push || finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_ok) begin
      top     <= in_data.start_vertex;
      pending <= in_data.start_vertex;
    end else if (push) begin
      top     <= nxt;
      pending <= nxt;
    end
    if (push) begin
      out_data.visited_vertex <= pending;
      out_data.last_visit     <= 1'b0;
    end else if (finish) begin
      out_data.visited_vertex <= pending;
      out_data.last_visit     <= 1'b1;
    end
  end

endmodule

### design/adjacency_matrix_dfs_order_unit.sv
// Top level: vertex count register, adjacency RAM, vertex stack RAM and sequencer.
//
// A row-write item goes straight into the adjacency RAM. A start item resets the
// visited mask to the start vertex and walks the graph depth first; each visited
// vertex leaves as one transfer, the last one flagged. Entering a vertex is an
// adjacency RAM read, then a scan of its row; coming back to it after each child
// is a vertex stack RAM read, then an adjacency RAM read. The walk stalls while a
// result is held.
// A new item is taken only after the last result of a traversal is registered.
// No clearing pass after reset; rows read before being written give unknown data.
module adjacency_matrix_dfs_order_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  amdfs_pkg::in_item_t         in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output amdfs_pkg::out_item_t        out_data,
  input  logic                        cfg_we,
  input  logic [amdfs_pkg::CNT_W-1:0] cfg_data
);

  logic [amdfs_pkg::CNT_W-1:0]  vertex_count;
  amdfs_pkg::row_port_t         row_port;
  amdfs_pkg::stack_port_t       stack_port;
  logic [amdfs_pkg::ROW_W-1:0]  row_rdata;
  logic [amdfs_pkg::VIDX_W-1:0] stack_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= amdfs_pkg::CNT_W'(amdfs_pkg::VERTS);
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  amdfs_ram #(
    .WIDTH(amdfs_pkg::ROW_W),
    .DEPTH(amdfs_pkg::VERTS)
  ) u_row_ram (
    .clk  (clk),
    .we   (row_port.we),
    .waddr(row_port.waddr),
    .wdata(row_port.wdata),
    .re   (row_port.re),
    .raddr(row_port.raddr),
    .rdata(row_rdata)
  );

  amdfs_ram #(
    .WIDTH(amdfs_pkg::VIDX_W),
    .DEPTH(amdfs_pkg::VERTS)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stack_port.we),
    .waddr(stack_port.waddr),
    .wdata(stack_port.wdata),
    .re   (stack_port.re),
    .raddr(stack_port.raddr),
    .rdata(stack_rdata)
  );

  amdfs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .vertex_count(vertex_count),
    .row_port    (row_port),
    .row_rdata   (row_rdata),
    .stack_port  (stack_port),
    .stack_rdata (stack_rdata)
  );

endmodule

### design/amdfs_checker.sv
// Port-level checks for the depth-first order unit, bound to the top level.
module amdfs_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input amdfs_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input amdfs_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_row_write_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.operation == amdfs_pkg::OP_ROW_WRITE) |=> in_ready)
    else $error("row write did not complete in one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.operation == amdfs_pkg::OP_START) |=> !in_ready)
    else $error("start transfer did not begin a traversal");

  a_mid_walk_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_visit |-> !in_ready)
    else $error("input taken before traversal finished");

endmodule

bind adjacency_matrix_dfs_order_unit amdfs_checker u_amdfs_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
